// ----- rtl/core/dwg_pkg.sv -----
// dwg_pkg: widths, register codes, sideband structs and constant helpers for the
// dose weight generator; used by every module in rtl/core except dwg_checker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dwg_pkg;

	localparam int FracBits = 16;
	localparam int BoxW = 13;
	localparam int YW = 14;
	localparam int K2W = 24;
	localparam int LogW = 5 + FracBits;
	localparam int LW = 24;
	localparam int DoseW = 43;
	localparam int NumW = DoseW + FracBits;
	localparam int DenW = 63;
	localparam int QW = 22;
	localparam int MantW = 32;
	localparam int AddrW = 5;
	localparam int RoundBase = 30 - FracBits;
	localparam logic [30:0] Log2eQ30 = 31'd1549082005;
	localparam logic [16:0] WeightOne = 17'd65536;
	localparam logic [62:0] SatLim = 63'd1 << 62;

	typedef enum logic [2:0] {
		RegCoefScale    = 3'd0,
		RegCoefExponent = 3'd1,
		RegCoefOffset   = 3'd2,
		RegDosePerFrame = 3'd3,
		RegFirstFrame   = 3'd4,
		RegBoxSize      = 3'd5,
		RegPixelSize    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [DoseW-1:0] dose;
		logic             k2_zero;
	} front_sb_t;

	typedef struct packed {
		logic signed [LW-1:0] ti;
		logic [DoseW-1:0]     dose;
		logic                 k2_zero;
	} pow_sb_t;

	typedef struct packed {
		logic forced;
		logic forced_one;
		logic clamp;
	} fin_t;

	typedef struct packed {
		logic [7:0] e;
		fin_t       fin;
	} tail_sb_t;

	// position of the highest set bit, zero for zero
	function automatic logic [4:0] lead_one(input logic [31:0] v);
		logic [4:0] e;
		e = '0;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) e = 5'(i);
		end
		return e;
	endfunction

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] b;
		rem = v;
		res = '0;
		b = 64'd1 << 62;
		for (int k = 0; k < 32; k++) begin
			if (rem >= res + b) begin
				rem = rem - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// repeated square roots of two in Q30, entry k is 2^(2^-(k+1))
	function automatic logic [FracBits-1:0][31:0] root_table();
		logic [FracBits-1:0][31:0] t;
		logic [63:0] r;
		r = 64'd2 << 30;
		for (int k = 0; k < FracBits; k++) begin
			r = isqrt64(r << 30);
			t[k] = r[31:0];
		end
		return t;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dwg_log2.sv -----
// dwg_log2: pipelined base-2 logarithm over parallel lanes, one fraction bit per stage
// by squaring a normalized mantissa; depends on dwg_pkg
`timescale 1ns / 1ps
`default_nettype none

module dwg_log2 #(
	parameter int LANES = 3,
	parameter int SBW = 1
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   in_valid,
	input  logic [LANES-1:0][31:0]                 in_val,
	input  logic [SBW-1:0]                         in_sb,
	output logic                                   out_valid,
	output logic [LANES-1:0][dwg_pkg::LogW-1:0]    out_log,
	output logic [SBW-1:0]                         out_sb
);

	localparam int NS = dwg_pkg::FracBits + 1;

	logic [NS-1:0]                              v_s;
	logic [SBW-1:0]                             sb_s [NS];
	logic [LANES-1:0][31:0]                     m_s  [NS];
	logic [LANES-1:0][4:0]                      e_s  [NS];
	logic [LANES-1:0][dwg_pkg::FracBits-1:0]    fr_s [NS];
	logic [LANES-1:0][32:0]                     sq   [NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[NS-2:0], in_valid};
		end
	end

	// squared mantissa shifted back to a Q31 scale
	always_comb begin
		sq[0] = '0;
		for (int k = 1; k < NS; k++) begin
			for (int l = 0; l < LANES; l++) begin
				sq[k][l] = 33'((64'(m_s[k-1][l]) * 64'(m_s[k-1][l])) >> 31);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s[0] <= in_sb;
			for (int l = 0; l < LANES; l++) begin
				e_s[0][l]  <= dwg_pkg::lead_one(in_val[l]);
				m_s[0][l]  <= in_val[l] << (5'd31 - dwg_pkg::lead_one(in_val[l]));
				fr_s[0][l] <= '0;
			end
			for (int k = 1; k < NS; k++) begin
				sb_s[k] <= sb_s[k-1];
				e_s[k]  <= e_s[k-1];
				for (int l = 0; l < LANES; l++) begin
					if (sq[k][l][32]) begin
						m_s[k][l]  <= sq[k][l][32:1];
						fr_s[k][l] <= fr_s[k-1][l]
							| (dwg_pkg::FracBits'(1) << (NS - 1 - k));
					end else begin
						m_s[k][l]  <= sq[k][l][31:0];
						fr_s[k][l] <= fr_s[k-1][l];
					end
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			out_log[l] = {e_s[NS-1][l], fr_s[NS-1][l]};
		end
	end

	assign out_valid = v_s[NS-1];
	assign out_sb    = sb_s[NS-1];

endmodule

`default_nettype wire

// ----- rtl/core/dwg_exp2.sv -----
// dwg_exp2: pipelined 2^f for a fraction f, one product with a root of two per stage
// result in Q30; depends on dwg_pkg
`timescale 1ns / 1ps
`default_nettype none

module dwg_exp2 #(
	parameter int SBW = 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic [dwg_pkg::FracBits-1:0]      in_f,
	input  logic [SBW-1:0]                    in_sb,
	output logic                              out_valid,
	output logic [dwg_pkg::MantW-1:0]         out_mant,
	output logic [SBW-1:0]                    out_sb
);

	localparam int NS = dwg_pkg::FracBits;
	localparam logic [NS-1:0][31:0] Roots = dwg_pkg::root_table();

	logic [NS-1:0]   v_s;
	logic [SBW-1:0]  sb_s  [NS];
	logic [31:0]     acc_s [NS];
	logic [NS-1:0]   f_s   [NS];
	logic [31:0]     acc_i [NS];
	logic [NS-1:0]   f_i   [NS];
	logic [31:0]     nxt   [NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[NS-2:0], in_valid};
		end
	end

	always_comb begin
		acc_i[0] = 32'd1 << 30;
		f_i[0]   = in_f;
		for (int k = 1; k < NS; k++) begin
			acc_i[k] = acc_s[k-1];
			f_i[k]   = f_s[k-1];
		end
		for (int k = 0; k < NS; k++) begin
			if (f_i[k][NS-1-k]) begin
				nxt[k] = 32'((64'(acc_i[k]) * 64'(Roots[k])) >> 30);
			end else begin
				nxt[k] = acc_i[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s[0] <= in_sb;
			for (int k = 1; k < NS; k++) sb_s[k] <= sb_s[k-1];
			for (int k = 0; k < NS; k++) begin
				acc_s[k] <= nxt[k];
				f_s[k]   <= f_i[k];
			end
		end
	end

	assign out_valid = v_s[NS-1];
	assign out_mant  = acc_s[NS-1];
	assign out_sb    = sb_s[NS-1];

endmodule

`default_nettype wire

// ----- rtl/core/dwg_div.sv -----
// dwg_div: pipelined restoring divider, one quotient bit per stage, for a quotient
// known to fit dwg_pkg::QW bits; depends on dwg_pkg
`timescale 1ns / 1ps
`default_nettype none

module dwg_div #(
	parameter int SBW = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [dwg_pkg::NumW-1:0]      in_num,
	input  logic [dwg_pkg::DenW-1:0]      in_den,
	input  logic [SBW-1:0]                in_sb,
	output logic                          out_valid,
	output logic [dwg_pkg::QW-1:0]        out_q,
	output logic [SBW-1:0]                out_sb
);

	localparam int NS = dwg_pkg::QW;
	localparam int CW = dwg_pkg::DenW + dwg_pkg::QW;

	logic [NS-1:0]                 v_s;
	logic [SBW-1:0]                sb_s  [NS];
	logic [dwg_pkg::NumW-1:0]      rem_s [NS];
	logic [dwg_pkg::DenW-1:0]      den_s [NS];
	logic [NS-1:0]                 q_s   [NS];
	logic [dwg_pkg::NumW-1:0]      rem_i [NS];
	logic [dwg_pkg::DenW-1:0]      den_i [NS];
	logic [NS-1:0]                 q_i   [NS];
	logic [CW-1:0]                 dsh   [NS];
	logic [NS-1:0]                 ge;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[NS-2:0], in_valid};
		end
	end

	always_comb begin
		rem_i[0] = in_num;
		den_i[0] = in_den;
		q_i[0]   = '0;
		for (int k = 1; k < NS; k++) begin
			rem_i[k] = rem_s[k-1];
			den_i[k] = den_s[k-1];
			q_i[k]   = q_s[k-1];
		end
		for (int k = 0; k < NS; k++) begin
			dsh[k] = CW'(den_i[k]) << (NS - 1 - k);
			ge[k]  = CW'(rem_i[k]) >= dsh[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s[0] <= in_sb;
			for (int k = 1; k < NS; k++) sb_s[k] <= sb_s[k-1];
			for (int k = 0; k < NS; k++) begin
				den_s[k] <= den_i[k];
				if (ge[k]) begin
					rem_s[k] <= rem_i[k] - dsh[k][dwg_pkg::NumW-1:0];
					q_s[k]   <= q_i[k] | (NS'(1) << (NS - 1 - k));
				end else begin
					rem_s[k] <= rem_i[k];
					q_s[k]   <= q_i[k];
				end
			end
		end
	end

	assign out_valid = v_s[NS-1];
	assign out_q     = q_s[NS-1];
	assign out_sb    = sb_s[NS-1];

endmodule

`default_nettype wire

// ----- rtl/core/dose_weight_generator_core.sv -----
// dose_weight_generator_core: per-pixel exposure dose weight exp(-dose/tau) in Q1.16
// depends on dwg_pkg, dwg_log2, dwg_exp2, dwg_div
//
// input channel: in_valid/in_stall with frame_index, column, row; one beat per pixel
// output channel: out_valid/out_stall with weight (Q1.16) and tau_clamped
// registers sit on an apb-style port: a, b, c, dose per frame, first frame, box size,
// pixel size at byte addresses 0, 4, ... 24; pready is always high, reads return values
// throughput: one beat per cycle in both directions while the output is not stalled
// pipeline: from input beat to output beat through a 17-stage log2 by squaring,
// two 16-stage 2^f units by root products and a 22-stage divider
// stall: a stalled output beat freezes the whole pipeline and raises in_stall in the
// same cycle; no beat is lost or repeated, and a new input beat is taken whenever the
// output register is empty or its beat leaves
// reset: arst_n clears all valid bits and loads the register defaults
// registers may be written only while no beat is in flight
`timescale 1ns / 1ps
`default_nettype none

module dose_weight_generator_core #(
	parameter int MAX_BOX = 1024,
	parameter int MAX_FRAMES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [9:0]  frame_index,
	input  logic [9:0]  column,
	input  logic [9:0]  row,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [16:0] weight,
	output logic        tau_clamped,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [dwg_pkg::AddrW-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int BW = dwg_pkg::BoxW;
	localparam logic [BW-1:0] MaxBoxC = BW'(MAX_BOX);
	localparam logic [16:0] MaxFrameC = 17'(MAX_FRAMES - 1);

	// config registers
	logic [31:0] coef_scale_q, coef_exponent_q, coef_offset_q, dose_per_frame_q;
	logic [31:0] pixel_size_q;
	logic [9:0]  first_frame_q;
	logic [10:0] box_size_q;
	dwg_pkg::reg_idx_t ridx;

	assign ridx   = dwg_pkg::reg_idx_t'(paddr[4:2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_scale_q     <= 32'd16056;
			coef_exponent_q  <= 32'hFFFE_55C3;
			coef_offset_q    <= 32'd184156;
			dose_per_frame_q <= 32'd65536;
			first_frame_q    <= '0;
			box_size_q       <= 11'd256;
			pixel_size_q     <= 32'd65536;
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				dwg_pkg::RegCoefScale:    coef_scale_q     <= pwdata;
				dwg_pkg::RegCoefExponent: coef_exponent_q  <= pwdata;
				dwg_pkg::RegCoefOffset:   coef_offset_q    <= pwdata;
				dwg_pkg::RegDosePerFrame: dose_per_frame_q <= pwdata;
				dwg_pkg::RegFirstFrame:   first_frame_q    <= pwdata[9:0];
				dwg_pkg::RegBoxSize:      box_size_q       <= pwdata[10:0];
				dwg_pkg::RegPixelSize:    pixel_size_q     <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			dwg_pkg::RegCoefScale:    prdata = coef_scale_q;
			dwg_pkg::RegCoefExponent: prdata = coef_exponent_q;
			dwg_pkg::RegCoefOffset:   prdata = coef_offset_q;
			dwg_pkg::RegDosePerFrame: prdata = dose_per_frame_q;
			dwg_pkg::RegFirstFrame:   prdata = 32'(first_frame_q);
			dwg_pkg::RegBoxSize:      prdata = 32'(box_size_q);
			dwg_pkg::RegPixelSize:    prdata = pixel_size_q;
			default:                  prdata = '0;
		endcase
	end

	// pipeline enable
	logic en;
	logic v_s80;
	assign en       = !(v_s80 && out_stall);
	assign in_stall = !en;

	// derived config
	logic [BW-1:0] box_s, kc;
	logic [31:0]   s2, pix;
	always_comb begin
		if (box_size_q < 11'd2) box_s = BW'(2);
		else if (BW'(box_size_q) > MaxBoxC) box_s = MaxBoxC;
		else box_s = BW'(box_size_q);
		kc  = (box_s >> 1) + BW'(1);
		s2  = 32'({box_s[BW-1:1], 1'b0});
		pix = (pixel_size_q == '0) ? 32'd1 : pixel_size_q;
	end

	// stage 1: dose and squared radius
	logic [9:0]                    frame_c;
	logic [10:0]                   fsum;
	logic signed [dwg_pkg::YW-1:0] yv;
	logic [dwg_pkg::YW-1:0]        yabs;
	logic [dwg_pkg::K2W-1:0]       k2_c;
	logic                          v_s1;
	logic [dwg_pkg::DoseW-1:0]     dose_s1;
	logic [dwg_pkg::K2W-1:0]       k2_s1;
	dwg_pkg::front_sb_t            fsb_s1;

	always_comb begin
		frame_c = (17'(frame_index) > MaxFrameC) ? 10'(MAX_FRAMES - 1) : frame_index;
		fsum    = 11'(frame_c) + 11'(first_frame_q);
		if (BW'(row) < kc) yv = dwg_pkg::YW'(row);
		else yv = dwg_pkg::YW'(row) - dwg_pkg::YW'(box_s);
		yabs = yv[dwg_pkg::YW-1] ? dwg_pkg::YW'(-yv) : dwg_pkg::YW'(yv);
		k2_c = dwg_pkg::K2W'(column) * dwg_pkg::K2W'(column)
			+ dwg_pkg::K2W'(yabs) * dwg_pkg::K2W'(yabs);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dose_s1 <= dwg_pkg::DoseW'(fsum) * dwg_pkg::DoseW'(dose_per_frame_q);
			k2_s1   <= k2_c;
		end
	end

	assign fsb_s1.dose    = dose_s1;
	assign fsb_s1.k2_zero = (k2_s1 == '0);

	// stages 2 to 18: logarithms of radius squared, box and pixel size
	logic                               lg_valid;
	logic [2:0][dwg_pkg::LogW-1:0]      lg_log;
	dwg_pkg::front_sb_t                 lg_sb;
	logic [2:0][31:0]                   lg_in;

	assign lg_in = {pix, s2, 32'(k2_s1)};

	dwg_log2 #(
		.LANES(3),
		.SBW($bits(dwg_pkg::front_sb_t))
	) u_log (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s1), .in_val(lg_in), .in_sb(fsb_s1),
		.out_valid(lg_valid), .out_log(lg_log), .out_sb(lg_sb)
	);

	// stage 19: log2 of spatial frequency
	logic                          v_s19;
	logic signed [dwg_pkg::LW-1:0] l_s19;
	dwg_pkg::front_sb_t            fsb_s19;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s19 <= 1'b0;
		else if (en) v_s19 <= lg_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l_s19 <= dwg_pkg::LW'(lg_log[0] >> 1) - dwg_pkg::LW'(lg_log[1])
				- dwg_pkg::LW'(lg_log[2])
				+ dwg_pkg::LW'(dwg_pkg::FracBits << dwg_pkg::FracBits);
			fsb_s19 <= lg_sb;
		end
	end

	// stage 20: t = b * log2(r)
	logic               v_s20;
	logic signed [55:0] prod_s20;
	dwg_pkg::front_sb_t fsb_s20;
	dwg_pkg::pow_sb_t   psb_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s20 <= 1'b0;
		else if (en) v_s20 <= v_s19;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s20 <= $signed({{24{coef_exponent_q[31]}}, coef_exponent_q})
				* $signed({{32{l_s19[dwg_pkg::LW-1]}}, l_s19});
			fsb_s20 <= fsb_s19;
		end
	end

	assign psb_in.ti      = prod_s20[55:32];
	assign psb_in.dose    = fsb_s20.dose;
	assign psb_in.k2_zero = fsb_s20.k2_zero;

	// stages 21 to 36: 2^frac(t)
	logic                       e1_valid;
	logic [dwg_pkg::MantW-1:0]  e1_mant;
	dwg_pkg::pow_sb_t           e1_sb;

	dwg_exp2 #(
		.SBW($bits(dwg_pkg::pow_sb_t))
	) u_pow (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s20), .in_f(prod_s20[31:16]), .in_sb(psb_in),
		.out_valid(e1_valid), .out_mant(e1_mant), .out_sb(e1_sb)
	);

	// stage 37: |a| * mantissa
	logic             v_s37;
	logic [63:0]      p_s37;
	dwg_pkg::pow_sb_t psb_s37;
	logic [31:0]      a_abs;

	assign a_abs = coef_scale_q[31] ? (32'd0 - coef_scale_q) : coef_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s37 <= 1'b0;
		else if (en) v_s37 <= e1_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s37   <= 64'(a_abs) * 64'(e1_mant);
			psb_s37 <= e1_sb;
		end
	end

	// stage 38: scale by 2^(int(t) - 30) with saturation
	logic                      v_s38;
	logic [62:0]               pm_s38;
	logic [dwg_pkg::DoseW-1:0] dose_s38;
	logic                      k2z_s38;
	logic signed [24:0]        sh;
	logic [24:0]               nsh;
	logic [62:0]               pm_c;

	always_comb begin
		sh  = 25'(psb_s37.ti) - 25'sd30;
		nsh = 25'(-sh);
		if (!sh[24]) begin
			if (p_s37 != '0 && (sh > 25'sd62
				|| p_s37 > (64'd1 << (6'd62 - sh[5:0])))) begin
				pm_c = dwg_pkg::SatLim;
			end else begin
				pm_c = 63'(p_s37 << sh[5:0]);
			end
		end else if (nsh > 25'd63) begin
			pm_c = '0;
		end else begin
			pm_c = 63'(p_s37 >> nsh[5:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s38 <= 1'b0;
		else if (en) v_s38 <= v_s37;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pm_s38   <= pm_c;
			dose_s38 <= psb_s37.dose;
			k2z_s38  <= psb_s37.k2_zero;
		end
	end

	// stage 39: tau = a * r^b + c
	logic                      v_s39;
	logic [63:0]               tau_s39;
	logic [dwg_pkg::DoseW-1:0] dose_s39;
	logic                      spec_s39;
	logic [63:0]               ps;

	always_comb begin
		// zero radius: r^b is one for b zero, else zero (negative b handled as special)
		if (k2z_s38) ps = (coef_exponent_q == '0) ? {{32{coef_scale_q[31]}}, coef_scale_q}
			: 64'd0;
		else if (coef_scale_q[31]) ps = 64'd0 - {1'b0, pm_s38};
		else ps = {1'b0, pm_s38};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s39 <= 1'b0;
		else if (en) v_s39 <= v_s38;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tau_s39  <= ps + {{32{coef_offset_q[31]}}, coef_offset_q};
			dose_s39 <= dose_s38;
			spec_s39 <= k2z_s38 && coef_exponent_q[31];
		end
	end

	// stage 40: clamp and range checks, divider operands
	logic                      v_s40;
	logic [dwg_pkg::NumW-1:0]  num_s40;
	logic [dwg_pkg::DenW-1:0]  den_s40;
	dwg_pkg::fin_t             fin_s40;
	dwg_pkg::fin_t             fin_c;
	logic                      clamped, ovf;

	always_comb begin
		clamped = tau_s39[63] || (tau_s39 == '0);
		ovf     = {26'b0, dose_s39} >= {tau_s39[62:0], 6'b0};
		fin_c.forced     = spec_s39 || clamped || ovf;
		fin_c.forced_one = spec_s39 || (clamped && dose_s39 == '0);
		fin_c.clamp      = !spec_s39 && clamped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s40 <= 1'b0;
		else if (en) v_s40 <= v_s39;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s40 <= {dose_s39, dwg_pkg::FracBits'(0)};
			den_s40 <= tau_s39[62:0];
			fin_s40 <= fin_c;
		end
	end

	// stages 41 to 62: dose / tau
	logic                    dv_valid;
	logic [dwg_pkg::QW-1:0]  dv_q;
	dwg_pkg::fin_t           dv_fin;

	dwg_div #(
		.SBW($bits(dwg_pkg::fin_t))
	) u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s40), .in_num(num_s40), .in_den(den_s40), .in_sb(fin_s40),
		.out_valid(dv_valid), .out_q(dv_q), .out_sb(dv_fin)
	);

	// stage 63: y = q * log2(e), split into exponent and fraction
	logic                         v_s63;
	logic [dwg_pkg::FracBits-1:0] f_s63;
	dwg_pkg::tail_sb_t            tsb_s63;
	logic [52:0]                  yp;
	logic [22:0]                  y;

	assign yp = 53'(dv_q) * 53'(dwg_pkg::Log2eQ30);
	assign y  = yp[52:30];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s63 <= 1'b0;
		else if (en) v_s63 <= dv_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// 2^-y = 2^(1 - frac) * 2^-(int + 1), or 2^-int for an exact integer
			f_s63       <= dwg_pkg::FracBits'(0) - y[dwg_pkg::FracBits-1:0];
			tsb_s63.e   <= 8'(y[22:16]) + 8'(y[dwg_pkg::FracBits-1:0] != '0);
			tsb_s63.fin <= dv_fin;
		end
	end

	// stages 64 to 79: mantissa of the weight
	logic                      e2_valid;
	logic [dwg_pkg::MantW-1:0] e2_mant;
	dwg_pkg::tail_sb_t         e2_sb;

	dwg_exp2 #(
		.SBW($bits(dwg_pkg::tail_sb_t))
	) u_wexp (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s63), .in_f(f_s63), .in_sb(tsb_s63),
		.out_valid(e2_valid), .out_mant(e2_mant), .out_sb(e2_sb)
	);

	// stage 80: round to Q1.16, output register
	logic [16:0] weight_s80;
	logic        clamp_s80;
	logic [8:0]  shamt;
	logic [63:0] wr;
	logic [16:0] w_c;

	always_comb begin
		shamt = 9'(dwg_pkg::RoundBase) + 9'(e2_sb.e);
		wr    = (64'(e2_mant) + (64'd1 << 6'(shamt - 9'd1))) >> shamt[5:0];
		if (e2_sb.fin.forced) w_c = e2_sb.fin.forced_one ? dwg_pkg::WeightOne : 17'd0;
		else if (shamt >= 9'd63) w_c = 17'd0;
		else w_c = wr[16:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s80 <= 1'b0;
		else if (en) v_s80 <= e2_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			weight_s80 <= w_c;
			clamp_s80  <= e2_sb.fin.clamp;
		end
	end

	assign out_valid   = v_s80;
	assign weight      = weight_s80;
	assign tau_clamped = clamp_s80;

endmodule

`default_nettype wire

// ----- rtl/core/dwg_checker.sv -----
// dwg_checker: port-level assertions for dose_weight_generator_core, bound to the top
// depends on dose_weight_generator_core ports only
`timescale 1ns / 1ps
`default_nettype none

module dwg_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_stall,
	input wire        out_valid,
	input wire        out_stall,
	input wire [16:0] weight,
	input wire        tau_clamped,
	input wire        pready
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("output beat right after reset");

	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> weight <= 17'd65536)
		else $error("weight above one");

	a_clamp_weight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tau_clamped |-> weight == 17'd0 || weight == 17'd65536)
		else $error("clamped tau with fractional weight");

	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall && pready)
		else $error("input stalled without a stalled output beat");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(weight) && $stable(tau_clamped))
		else $error("stalled output beat changed");

endmodule

bind dose_weight_generator_core dwg_checker u_dwg_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.weight(weight),
	.tau_clamped(tau_clamped),
	.pready(pready)
);

`default_nettype wire
